/* src/resc_pkg.sv */
// Shared types, constants and helper functions for the readout event sanity checker.
// Used by the channel interfaces and every module of the block; depends on nothing.
`timescale 1ns / 1ps

package resc_pkg;

   // Field widths
   localparam int WORD_W  = 32;
   localparam int SIZE_W  = 30;
   localparam int ID_W    = 36;
   localparam int CHECK_W = 7;

   // Check enable / error mask bit positions
   localparam int EN_SIZES   = 0;
   localparam int EN_PATTERN = 1;
   localparam int EN_START   = 2;
   localparam int EN_END     = 3;
   localparam int EN_ID      = 4;
   localparam int EN_DIU     = 5;
   localparam int EN_CMPL    = 6;

   localparam logic [CHECK_W-1:0] CHECK_RESET = 7'h7f;

   // Event format constants
   localparam logic [WORD_W-1:0] START_WORD     = 32'hffff_ffff;
   localparam logic [7:0]        HDR_VERSION_3  = 8'h03;
   localparam logic [3:0]        HDR_LEN_SHORT  = 4'd8;
   localparam logic [3:0]        HDR_LEN_LONG   = 4'd10;

   // Header word positions
   localparam logic [SIZE_W-1:0] IDX_START   = 30'd0;
   localparam logic [SIZE_W-1:0] IDX_ID_LOW  = 30'd1;
   localparam logic [SIZE_W-1:0] IDX_ID_HIGH = 30'd2;
   localparam logic [SIZE_W-1:0] IDX_MODE    = 30'd3;
   localparam logic [SIZE_W-1:0] IDX_SEED    = 30'd4;

   // Payload pattern generators
   localparam logic [1:0] PAT_INC = 2'd0;
   localparam logic [1:0] PAT_DEC = 2'd1;
   localparam logic [1:0] PAT_ROL = 2'd2;
   localparam logic [1:0] PAT_INV = 2'd3;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Classified item kinds
   typedef enum logic [1:0] {
      ITEM_OPEN,
      ITEM_WORD,
      ITEM_END
   } item_kind_type;

   // One classified transaction; for ITEM_OPEN word_a/word_b hold the
   // calculated and reported words, otherwise word_a is the event word.
   typedef struct packed {
      item_kind_type      kind;
      logic [SIZE_W-1:0]  index;
      logic [WORD_W-1:0]  word_a;
      logic [WORD_W-1:0]  word_b;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Next value of the payload generator
   function automatic logic [WORD_W-1:0] advance_pattern(input logic [1:0] sel,
                                                          input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] r;
      begin
         unique case (sel)
            PAT_INC: r = w + 32'd1;
            PAT_DEC: r = w - 32'd1;
            PAT_ROL: r = {w[WORD_W-2:0], w[WORD_W-1]};
            PAT_INV: r = ~w;
            default: r = w;
         endcase
         return r;
      end
   endfunction

endpackage

/* src/resc_if.sv */
// Valid/ready channel interfaces: request, response and register write port.
// Depends on resc_pkg for field widths.
`timescale 1ns / 1ps

interface resc_req_if;
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic [resc_pkg::WORD_W-1:0]  calc_word;
   logic [resc_pkg::WORD_W-1:0]  reported_word;
   logic [resc_pkg::WORD_W-1:0]  data_word;

   modport source (output valid, mode, calc_word, reported_word, data_word, input ready);
   modport sink   (input valid, mode, calc_word, reported_word, data_word, output ready);
endinterface

interface resc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [resc_pkg::CHECK_W-1:0]  error_mask;
   logic [resc_pkg::ID_W-1:0]     event_tag;
   logic [resc_pkg::WORD_W-1:0]   error_total;

   modport source (output valid, error_mask, event_tag, error_total, input ready);
   modport sink   (input valid, error_mask, event_tag, error_total, output ready);
endinterface

interface resc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [resc_pkg::CHECK_W-1:0]  data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

/* src/resc_front.sv */
// Front end: accepts request transactions, tracks event framing and word index,
// and pushes classified entries into the queue. Depends on resc_pkg, resc_if.
`timescale 1ns / 1ps

module resc_front (
   input  logic                        clock,
   input  logic                        reset,
   resc_req_if.sink                    req_bus,
   input  resc_pkg::queue_status_type  q_status,
   output logic                        push,
   output resc_pkg::entry_type         push_entry
);

   logic                          in_event_ff, in_event_in;
   logic [resc_pkg::SIZE_W-1:0]   index_ff,    index_in;
   logic [resc_pkg::SIZE_W-1:0]   size_ff,     size_in;
   logic                          accept;

   // Take a transaction whenever the queue has room
   assign req_bus.ready = !q_status.full;
   assign accept        = req_bus.valid && req_bus.ready;

   // Classify and advance the framing state
   always_comb begin
      in_event_in       = in_event_ff;
      index_in          = index_ff;
      size_in           = size_ff;
      push              = 1'b0;
      push_entry.kind   = resc_pkg::ITEM_WORD;
      push_entry.index  = index_ff;
      push_entry.word_a = req_bus.data_word;
      push_entry.word_b = req_bus.reported_word;
      if (accept) begin
         if (!req_bus.mode) begin
            // descriptor: opens an event, dropping any open one
            push              = 1'b1;
            push_entry.kind   = resc_pkg::ITEM_OPEN;
            push_entry.word_a = req_bus.calc_word;
            in_event_in       = 1'b1;
            index_in          = '0;
            size_in           = req_bus.calc_word[resc_pkg::SIZE_W-1:0];
         end else if (in_event_ff) begin
            push = 1'b1;
            if (index_ff < size_ff) begin
               index_in = index_ff + 30'd1;
            end else begin
               push_entry.kind = resc_pkg::ITEM_END;
               in_event_in     = 1'b0;
               index_in        = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_event_ff <= 1'b0;
         index_ff    <= '0;
         size_ff     <= '0;
      end else begin
         in_event_ff <= in_event_in;
         index_ff    <= index_in;
         size_ff     <= size_in;
      end
   end

   // Index is parked at zero between events
   assert property (@(posedge clock) disable iff (reset) !in_event_ff |-> index_ff == '0)
      else $error("word index not cleared outside an event");

   // Nothing is pushed into a full queue
   assert property (@(posedge clock) disable iff (reset) push |-> !q_status.full)
      else $error("push into full queue");

   // Every push comes from an accepted transaction
   assert property (@(posedge clock) disable iff (reset)
                    push |-> (req_bus.valid && req_bus.ready))
      else $error("push without an accepted transaction");

endmodule

/* src/resc_queue.sv */
// Short FIFO of classified entries between the front and back ends.
// Depends on resc_pkg.
`timescale 1ns / 1ps

module resc_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  resc_pkg::entry_type         push_entry,
   input  logic                        pop,
   output resc_pkg::entry_type         head_entry,
   output resc_pkg::queue_status_type  status
);

   resc_pkg::entry_type                   store_ff [resc_pkg::QUEUE_DEPTH];
   logic [resc_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [resc_pkg::QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [resc_pkg::QUEUE_CNT_W-1:0]      count_ff,  count_in;

   localparam logic [resc_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      resc_pkg::QUEUE_PTR_W'(resc_pkg::QUEUE_DEPTH - 1);
   localparam logic [resc_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
      resc_pkg::QUEUE_CNT_W'(resc_pkg::QUEUE_DEPTH);

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign head_entry   = store_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_CNT)
      else $error("queue occupancy beyond depth");

   assert property (@(posedge clock) disable iff (reset) pop |-> !status.empty)
      else $error("pop from empty queue");

   assert property (@(posedge clock) disable iff (reset)
                    (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("occupancy did not follow push");

endmodule

/* src/resc_back.sv */
// Back end: runs the per-word checks on queued entries, holds the check enable
// register and the result output register. Depends on resc_pkg, resc_if.
`timescale 1ns / 1ps

module resc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  resc_pkg::entry_type         head_entry,
   input  resc_pkg::queue_status_type  q_status,
   output logic                        pop,
   resc_rsp_if.source                  rsp_bus,
   resc_csr_if.sink                    csr_bus
);

   logic [resc_pkg::CHECK_W-1:0]  check_enable_ff, check_enable_in;

   // Event state
   logic [resc_pkg::SIZE_W-1:0]   event_size_ff,   event_size_in;
   logic [resc_pkg::SIZE_W-1:0]   exp_size_ff,     exp_size_in;
   logic                          link_error_ff,   link_error_in;
   logic [1:0]                    cmpl_code_ff,    cmpl_code_in;
   logic                          hdr_long_ff,     hdr_long_in;
   logic [1:0]                    pat_mode_ff,     pat_mode_in;
   logic [resc_pkg::WORD_W-1:0]   pattern_ff,      pattern_in;
   logic                          start_err_ff,    start_err_in;
   logic                          pat_err_ff,      pat_err_in;
   logic [resc_pkg::ID_W-1:0]     cur_id_ff,       cur_id_in;
   logic [resc_pkg::ID_W-1:0]     next_id_ff,      next_id_in;
   logic                          id_valid_ff,     id_valid_in;
   logic [resc_pkg::WORD_W-1:0]   err_count_ff,    err_count_in;

   // Output register
   logic                          rsp_valid_ff,    rsp_valid_in;
   logic [resc_pkg::CHECK_W-1:0]  rsp_mask_ff,     rsp_mask_in;
   logic [resc_pkg::ID_W-1:0]     rsp_id_ff,       rsp_id_in;
   logic [resc_pkg::WORD_W-1:0]   rsp_total_ff,    rsp_total_in;

   logic                          is_end;
   logic                          end_pop;
   logic [resc_pkg::WORD_W-1:0]   w;
   logic [resc_pkg::SIZE_W-1:0]   idx;
   logic [3:0]                    hdr_len;
   logic                          start_err_now;
   logic [resc_pkg::CHECK_W-1:0]  raw;
   logic [resc_pkg::CHECK_W-1:0]  mask;

   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.error_mask  = rsp_mask_ff;
   assign rsp_bus.event_tag   = rsp_id_ff;
   assign rsp_bus.error_total = rsp_total_ff;

   // Words keep draining while a result waits; only an end word needs the slot
   assign is_end  = (head_entry.kind == resc_pkg::ITEM_END);
   assign pop     = !q_status.empty && (!is_end || !rsp_valid_ff || rsp_bus.ready);
   assign end_pop = pop && is_end;

   assign w       = head_entry.word_a;
   assign idx     = head_entry.index;
   assign hdr_len = hdr_long_ff ? resc_pkg::HDR_LEN_LONG : resc_pkg::HDR_LEN_SHORT;

   // Check enable register
   always_comb begin
      check_enable_in = check_enable_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         check_enable_in = csr_bus.data;
      end
   end

   // Per-entry checks and event state update
   always_comb begin
      event_size_in = event_size_ff;
      exp_size_in   = exp_size_ff;
      link_error_in = link_error_ff;
      cmpl_code_in  = cmpl_code_ff;
      hdr_long_in   = hdr_long_ff;
      pat_mode_in   = pat_mode_ff;
      pattern_in    = pattern_ff;
      start_err_in  = start_err_ff;
      pat_err_in    = pat_err_ff;
      cur_id_in     = cur_id_ff;
      next_id_in    = next_id_ff;
      id_valid_in   = id_valid_ff;
      err_count_in  = err_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_mask_in   = rsp_mask_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_total_in  = rsp_total_ff;
      start_err_now = start_err_ff;
      raw           = '0;
      mask          = '0;

      if (pop) begin
         unique case (head_entry.kind)
            resc_pkg::ITEM_OPEN: begin
               event_size_in = head_entry.word_a[resc_pkg::SIZE_W-1:0];
               cmpl_code_in  = head_entry.word_a[31:30];
               exp_size_in   = head_entry.word_b[resc_pkg::SIZE_W-1:0];
               link_error_in = head_entry.word_b[30];
               hdr_long_in   = 1'b0;
               pat_mode_in   = resc_pkg::PAT_INC;
               pattern_in    = '0;
               start_err_in  = 1'b0;
               pat_err_in    = 1'b0;
               cur_id_in     = '0;
            end
            resc_pkg::ITEM_WORD,
            resc_pkg::ITEM_END: begin
               // header fields
               if (idx == resc_pkg::IDX_START && w != resc_pkg::START_WORD) begin
                  start_err_now = 1'b1;
               end
               start_err_in = start_err_now;
               if (idx == resc_pkg::IDX_ID_LOW) begin
                  cur_id_in[11:0] = w[11:0];
                  hdr_long_in     = (w[31:24] == resc_pkg::HDR_VERSION_3);
               end
               if (idx == resc_pkg::IDX_ID_HIGH) begin
                  cur_id_in[resc_pkg::ID_W-1:12] = w[23:0];
               end
               if (idx == resc_pkg::IDX_MODE) begin
                  pat_mode_in = w[4:3];
               end
               if (idx == resc_pkg::IDX_SEED) begin
                  pattern_in = w;
               end

               if (!is_end) begin
                  // payload word
                  if (idx >= {26'd0, hdr_len}) begin
                     if (w != pattern_ff) begin
                        pat_err_in = 1'b1;
                     end
                     pattern_in = resc_pkg::advance_pattern(pat_mode_ff, pattern_ff);
                  end
               end else begin
                  // end word: collect the result
                  raw[resc_pkg::EN_START]   = start_err_now;
                  raw[resc_pkg::EN_PATTERN] = pat_err_ff ||
                     (event_size_ff <= {26'd0, (hdr_long_in ? resc_pkg::HDR_LEN_LONG
                                                             : resc_pkg::HDR_LEN_SHORT)});
                  raw[resc_pkg::EN_SIZES]   = (event_size_ff != exp_size_ff);
                  raw[resc_pkg::EN_END]     = (w[30:0] != {1'b0, exp_size_ff});
                  raw[resc_pkg::EN_DIU]     = link_error_ff;
                  raw[resc_pkg::EN_CMPL]    = link_error_ff || (cmpl_code_ff != 2'd0);
                  if (check_enable_ff[resc_pkg::EN_ID]) begin
                     raw[resc_pkg::EN_ID] = id_valid_ff && (cur_id_in != next_id_ff);
                     next_id_in  = cur_id_in + 36'd1;
                     id_valid_in = 1'b1;
                  end
                  mask = raw & check_enable_ff;
                  if (mask != '0 && err_count_ff != '1) begin
                     err_count_in = err_count_ff + 32'd1;
                  end
                  rsp_valid_in = 1'b1;
                  rsp_mask_in  = mask;
                  rsp_id_in    = cur_id_in;
                  rsp_total_in = err_count_in;
                  start_err_in = 1'b0;
                  pat_err_in   = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_enable_ff <= resc_pkg::CHECK_RESET;
         event_size_ff   <= '0;
         exp_size_ff     <= '0;
         link_error_ff   <= 1'b0;
         cmpl_code_ff    <= '0;
         hdr_long_ff     <= 1'b0;
         pat_mode_ff     <= resc_pkg::PAT_INC;
         pattern_ff      <= '0;
         start_err_ff    <= 1'b0;
         pat_err_ff      <= 1'b0;
         cur_id_ff       <= '0;
         next_id_ff      <= '0;
         id_valid_ff     <= 1'b0;
         err_count_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         check_enable_ff <= check_enable_in;
         event_size_ff   <= event_size_in;
         exp_size_ff     <= exp_size_in;
         link_error_ff   <= link_error_in;
         cmpl_code_ff    <= cmpl_code_in;
         hdr_long_ff     <= hdr_long_in;
         pat_mode_ff     <= pat_mode_in;
         pattern_ff      <= pattern_in;
         start_err_ff    <= start_err_in;
         pat_err_ff      <= pat_err_in;
         cur_id_ff       <= cur_id_in;
         next_id_ff      <= next_id_in;
         id_valid_ff     <= id_valid_in;
         err_count_ff    <= err_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Result payload, no reset
   always_ff @(posedge clock) begin
      rsp_mask_ff  <= rsp_mask_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_total_ff <= rsp_total_in;
   end

   // An end word always lands in the output register
   assert property (@(posedge clock) disable iff (reset) end_pop |=> rsp_valid_ff)
      else $error("end word produced no result");

   // An end word never overwrites a result still waiting
   assert property (@(posedge clock) disable iff (reset)
                    end_pop |-> (!rsp_valid_ff || rsp_bus.ready))
      else $error("result overwritten");

   // The error counter only moves on an end word
   assert property (@(posedge clock) disable iff (reset)
                    !end_pop |=> $stable(err_count_ff))
      else $error("error count changed without an end word");

endmodule

/* src/readout_event_sanity_checker_core.sv */
// Top level of the readout event sanity checker: front end, queue and back end.
// Depends on resc_pkg, resc_if, resc_front, resc_queue, resc_back.
`timescale 1ns / 1ps

// Usage
//   req_bus : one transaction per event descriptor (mode 0) or event word
//             (mode 1). A descriptor opens an event; words follow from index 0.
//   rsp_bus : one transaction per event, on its end word (the word at index
//             size): error mask, 36-bit event ID and the saturating error total.
//   csr_bus : writes the 7-bit check enable register; always ready. Write it
//             only while no event is in flight.
// Throughput: one request transaction per cycle while the queue has room;
//   non-end words keep draining while a result waits in the output register.
// Result path: an end word goes through the queue and the output register;
//   it is popped once at the queue head and the output register is free.
// Stall: when rsp_bus stalls, the back end keeps draining non-end words; an
//   end word waits at the head of the 4-entry queue, and req_bus.ready drops
//   once the queue fills.
// Reset: queue empty, no event open, no previous event ID, error total zero,
//   check enable set to all ones.

module readout_event_sanity_checker_core (
   input  logic         clock,
   input  logic         reset,
   resc_req_if.sink     req_bus,
   resc_rsp_if.source   rsp_bus,
   resc_csr_if.sink     csr_bus
);

   logic                        push;
   logic                        pop;
   resc_pkg::entry_type         push_entry;
   resc_pkg::entry_type         head_entry;
   resc_pkg::queue_status_type  q_status;

   // Framing and classification
   resc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   // Decoupling queue
   resc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   // Checks and result
   resc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_bus    (rsp_bus),
      .csr_bus    (csr_bus)
   );

endmodule
